### rtl/core/gaussian_blur_7x7_stream_unit_defines.svh
// Assertion macros shared by the blur RTL.
// No dependencies; included by the files that carry checks.
`ifndef GAUSSIAN_BLUR_7X7_STREAM_UNIT_DEFINES_SVH
`define GAUSSIAN_BLUR_7X7_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define GB7_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define GB7_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/gblur7_pkg.sv
// Shared constants, types and kernel weights for the 7x7 blur.
// No dependencies; used by every module of the block.
`default_nettype none

package gblur7_pkg;

    localparam int MAX_WIDTH  = 1920;
    localparam int MAX_HEIGHT = 1080;
    localparam int MIN_DIM    = 4;

    localparam int DIM_W   = 11;
    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = DIM_W;
    localparam int CNT_W   = 21;
    localparam int TAPS    = 7;
    localparam int HALF    = TAPS / 2;
    localparam int LINES   = TAPS - 1;
    localparam int WGT_W   = 10;
    localparam int FRAC    = 14;
    localparam int PROD_W  = PIX_W + WGT_W;
    localparam int PART_W  = 7;
    localparam int SUM_W   = 10;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [TAPS-1:0][PIX_W-1:0] col_t;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] hi
    );
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(MIN_DIM))
            r = DIM_W'(MIN_DIM);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // Kernel is symmetric: look up by distance from the center tap.
    function automatic logic [WGT_W-1:0] kern_weight(
        input logic [2:0] r,
        input logic [2:0] c
    );
        logic [2:0]       dr;
        logic [2:0]       dc;
        logic [WGT_W-1:0] w;
        dr = (r >= 3'd3) ? (r - 3'd3) : (3'd3 - r);
        dc = (c >= 3'd3) ? (c - 3'd3) : (3'd3 - c);
        case ({dr[1:0], dc[1:0]})
            4'b0000: w = 10'd765;
            4'b0001: w = 10'd675;
            4'b0010: w = 10'd464;
            4'b0011: w = 10'd248;
            4'b0100: w = 10'd675;
            4'b0101: w = 10'd595;
            4'b0110: w = 10'd409;
            4'b0111: w = 10'd219;
            4'b1000: w = 10'd464;
            4'b1001: w = 10'd409;
            4'b1010: w = 10'd281;
            4'b1011: w = 10'd150;
            4'b1100: w = 10'd248;
            4'b1101: w = 10'd219;
            4'b1110: w = 10'd150;
            4'b1111: w = 10'd80;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/gblur7_cell.sv
// One window column: holds seven pixels, passes them to its left neighbor,
// and registers its weighted column sum. Depends on gblur7_pkg.
`default_nettype none

module gblur7_cell (
    input  wire                              clk,
    input  gblur7_pkg::cell_ctl_t            ctl,
    input  wire  [2:0]                       tap,
    input  wire                              keep,
    input  gblur7_pkg::col_t                 col_in,
    output gblur7_pkg::col_t                 col_out,
    output logic [gblur7_pkg::PART_W-1:0]    partial
);

    gblur7_pkg::col_t                  col_reg;
    logic [gblur7_pkg::PART_W-1:0]     part_reg;
    logic [gblur7_pkg::PART_W-1:0]     part_next;
    logic [gblur7_pkg::PROD_W-1:0]     prod [gblur7_pkg::TAPS];

    always_comb
    begin
        part_next = '0;
        for (int k = 0; k < gblur7_pkg::TAPS; k++)
        begin
            prod[k] = gblur7_pkg::PROD_W'(col_reg[k])
                    * gblur7_pkg::PROD_W'(gblur7_pkg::kern_weight(3'(k), tap));
            part_next = part_next
                      + gblur7_pkg::PART_W'(prod[k] >> gblur7_pkg::FRAC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
            col_reg <= col_in;
        // drop columns that fall outside the image
        if (ctl.load)
            part_reg <= keep ? part_next : '0;
    end

    assign col_out = col_reg;
    assign partial = part_reg;

endmodule

`default_nettype wire

### rtl/core/gblur7_line_buf.sv
// Six line stores packed into one memory word per column, read-then-write.
// Depends on gblur7_pkg.
`default_nettype none

module gblur7_line_buf (
    input  wire                              clk,
    input  wire                              adv,
    input  wire  [gblur7_pkg::COL_W-1:0]     rd_addr,
    input  wire                              wr_en,
    input  wire  [gblur7_pkg::COL_W-1:0]     wr_addr,
    input  wire  [gblur7_pkg::LINES-1:0]     row_ok,
    input  gblur7_pkg::pix_t                 pix,
    output gblur7_pkg::col_t                 col
);

    localparam int WORD_W = gblur7_pkg::LINES * gblur7_pkg::PIX_W;

    logic [WORD_W-1:0] mem [gblur7_pkg::MAX_WIDTH];
    logic [WORD_W-1:0] rd_reg;
    logic [WORD_W-1:0] wr_word;

    always_ff @(posedge clk)
    begin
        if (adv)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_word;
    end

    // Rows above the frame's top read as zero: the store is never swept.
    always_comb
    begin
        for (int k = 0; k < gblur7_pkg::LINES; k++)
            col[k] = row_ok[k] ? rd_reg[k*gblur7_pkg::PIX_W +: gblur7_pkg::PIX_W] : '0;
        col[gblur7_pkg::LINES] = pix;
        for (int k = 0; k < gblur7_pkg::LINES; k++)
            wr_word[k*gblur7_pkg::PIX_W +: gblur7_pkg::PIX_W] = col[k+1];
    end

endmodule

`default_nettype wire

### rtl/core/gaussian_blur_7x7_stream_unit.sv
// Top level of the streaming 7x7 Gaussian blur: frame counters, line store,
// a chain of seven column cells and the output register.
// Depends on gblur7_pkg, gblur7_line_buf, gblur7_cell and the defines header.
//
//  Channel   Valid          Stall          Payload
//  input     pixel_valid    pixel_stall    pixel
//  output    result_valid   result_stall   blurred, last
//  config    cfg_wen        -              cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; a result passes through
// the window shift, the column sums and the output register, in that order.
// The line-store memory port sets the rate.
// Reset clears counters and pipeline valids; the line store is not swept,
// rows above the top of a frame are masked by the row count.
// A stalled output freezes the whole pipeline and stalls the input.
`default_nettype none
`include "gaussian_blur_7x7_stream_unit_defines.svh"

module gaussian_blur_7x7_stream_unit (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wen,
    input  wire  [0:0]                       cfg_index,
    input  wire  [gblur7_pkg::DIM_W-1:0]     cfg_data,
    input  wire                              pixel_valid,
    output logic                             pixel_stall,
    input  wire  [gblur7_pkg::PIX_W-1:0]     pixel,
    output logic                             result_valid,
    input  wire                              result_stall,
    output logic [gblur7_pkg::PIX_W-1:0]     blurred,
    output logic                             last
);

    localparam int DIM_W = gblur7_pkg::DIM_W;
    localparam int COL_W = gblur7_pkg::COL_W;
    localparam int ROW_W = gblur7_pkg::ROW_W;
    localparam int CNT_W = gblur7_pkg::CNT_W;
    localparam int TAPS  = gblur7_pkg::TAPS;
    localparam int LINES = gblur7_pkg::LINES;
    localparam int HALF  = gblur7_pkg::HALF;

    // configuration and frame state
    logic [DIM_W-1:0] width_cfg_reg;
    logic [DIM_W-1:0] height_cfg_reg;
    logic [DIM_W-1:0] fw_reg;
    logic [DIM_W-1:0] fh_reg;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] thresh_reg;
    logic [CNT_W-1:0] taken_reg;
    logic [CNT_W-1:0] given_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // accept-stage logic
    logic                  adv;
    logic                  acc;
    logic                  first;
    logic [DIM_W-1:0]      w_cur;
    logic [DIM_W-1:0]      h_cur;
    logic [2*DIM_W-1:0]    area;
    logic [CNT_W-1:0]      thresh_next;
    logic                  emit0;
    logic                  last0;
    logic                  wrap0;
    gblur7_pkg::pix_t      pix0;
    logic [LINES-1:0]      row_ok0;
    logic [COL_W:0]        centre0;
    logic [COL_W+1:0]      ct0 [TAPS];
    logic [TAPS-1:0]       mask0;

    // pipeline stages
    logic                  v1_reg;
    logic                  emit1_reg;
    logic                  last1_reg;
    logic [COL_W-1:0]      j1_reg;
    gblur7_pkg::pix_t      pix1_reg;
    logic [LINES-1:0]      rowok1_reg;
    logic [TAPS-1:0]       mask1_reg;
    logic                  emit2_reg;
    logic                  last2_reg;
    logic [TAPS-1:0]       mask2_reg;
    logic                  emit3_reg;
    logic                  last3_reg;
    logic                  result_valid_reg;
    logic [gblur7_pkg::PIX_W-1:0] blurred_reg;
    logic                  last_reg;

    gblur7_pkg::col_t      new_col;
    gblur7_pkg::col_t      chain [TAPS+1];
    logic [gblur7_pkg::PART_W-1:0] partial [TAPS];
    logic [gblur7_pkg::SUM_W-1:0]  sum3;
    gblur7_pkg::cell_ctl_t cell_ctl;

    assign adv          = !result_valid_reg || !result_stall;
    assign acc          = pixel_valid && adv;
    assign pixel_stall  = !adv;
    assign result_valid = result_valid_reg;
    assign blurred      = blurred_reg;
    assign last         = last_reg;

    always_comb
    begin
        first = (taken_reg == '0);
        w_cur = first ? gblur7_pkg::clamp_dim(width_cfg_reg, DIM_W'(gblur7_pkg::MAX_WIDTH))
                      : fw_reg;
        h_cur = first ? gblur7_pkg::clamp_dim(height_cfg_reg, DIM_W'(gblur7_pkg::MAX_HEIGHT))
                      : fh_reg;
        area        = (2*DIM_W)'(w_cur) * (2*DIM_W)'(h_cur);
        thresh_next = (CNT_W'(w_cur) << 1) + CNT_W'(w_cur) + CNT_W'(HALF);
        emit0 = !first && (taken_reg >= thresh_reg) && (given_reg < total_reg);
        last0 = emit0 && (CNT_W'(given_reg + 1'b1) == total_reg);
        wrap0 = ((COL_W+1)'(col_reg) + 1'b1) >= (COL_W+1)'(w_cur);
        pix0  = (row_reg < h_cur) ? pixel : '0;
        for (int k = 0; k < LINES; k++)
            row_ok0[k] = (row_reg >= ROW_W'(LINES - k));
        // center column trails the input by three, wrapping into the prior row
        if (col_reg >= COL_W'(HALF))
            centre0 = (COL_W+1)'(col_reg) - (COL_W+1)'(HALF);
        else
            centre0 = (COL_W+1)'(col_reg) + (COL_W+1)'(w_cur) - (COL_W+1)'(HALF);
        for (int t = 0; t < TAPS; t++)
        begin
            ct0[t]   = (COL_W+2)'(centre0) + (COL_W+2)'(t);
            mask0[t] = (ct0[t] >= (COL_W+2)'(HALF))
                    && (ct0[t] < (COL_W+2)'(w_cur) + (COL_W+2)'(HALF));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= DIM_W'(gblur7_pkg::MAX_WIDTH);
            height_cfg_reg <= DIM_W'(gblur7_pkg::MAX_HEIGHT);
            fw_reg         <= DIM_W'(gblur7_pkg::MAX_WIDTH);
            fh_reg         <= DIM_W'(gblur7_pkg::MAX_HEIGHT);
            total_reg      <= CNT_W'(gblur7_pkg::MAX_WIDTH * gblur7_pkg::MAX_HEIGHT);
            thresh_reg     <= CNT_W'(3 * gblur7_pkg::MAX_WIDTH + HALF);
            taken_reg      <= '0;
            given_reg      <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (gblur7_pkg::cfg_reg_t'(cfg_index))
                    gblur7_pkg::REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    gblur7_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (acc)
            begin
                // latch the frame geometry on its first item
                if (first)
                begin
                    fw_reg     <= w_cur;
                    fh_reg     <= h_cur;
                    total_reg  <= area[CNT_W-1:0];
                    thresh_reg <= thresh_next;
                end
                if (last0)
                begin
                    taken_reg <= '0;
                    given_reg <= '0;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                else
                begin
                    taken_reg <= taken_reg + 1'b1;
                    given_reg <= given_reg + CNT_W'(emit0);
                    if (wrap0)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // pipeline valids and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            emit1_reg        <= 1'b0;
            emit2_reg        <= 1'b0;
            emit3_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg           <= acc;
            emit1_reg        <= acc && emit0;
            emit2_reg        <= emit1_reg;
            emit3_reg        <= emit2_reg;
            result_valid_reg <= emit3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (acc)
            begin
                j1_reg     <= col_reg;
                pix1_reg   <= pix0;
                rowok1_reg <= row_ok0;
                mask1_reg  <= mask0;
                last1_reg  <= last0;
            end
            mask2_reg <= mask1_reg;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
            if (emit3_reg)
            begin
                blurred_reg <= sum3[gblur7_pkg::PIX_W-1:0];
                last_reg    <= last3_reg;
            end
        end
    end

    gblur7_line_buf u_line_buf (
        .clk     (clk),
        .adv     (adv),
        .rd_addr (col_reg),
        .wr_en   (adv && v1_reg),
        .wr_addr (j1_reg),
        .row_ok  (rowok1_reg),
        .pix     (pix1_reg),
        .col     (new_col)
    );

    assign cell_ctl.shift = adv && v1_reg;
    assign cell_ctl.load  = adv;
    assign chain[TAPS]    = new_col;

    // cell t holds window column t; new columns enter at the right end
    for (genvar t = 0; t < TAPS; t++)
    begin : g_cell
        gblur7_cell u_cell (
            .clk     (clk),
            .ctl     (cell_ctl),
            .tap     (3'(t)),
            .keep    (mask2_reg[t]),
            .col_in  (chain[t+1]),
            .col_out (chain[t]),
            .partial (partial[t])
        );
    end

    always_comb
    begin
        sum3 = '0;
        for (int t = 0; t < TAPS; t++)
            sum3 = sum3 + gblur7_pkg::SUM_W'(partial[t]);
    end

    `GB7_ASSERT_NOW(a_stall_when_full, clk, rst_n,
        result_valid_reg && result_stall, pixel_stall,
        "input not stalled while output is held")
    `GB7_ASSERT_NOW(a_given_in_range, clk, rst_n,
        taken_reg != '0, given_reg < total_reg,
        "result count passed the frame size")
    `GB7_ASSERT_NOW(a_col_in_row, clk, rst_n,
        taken_reg != '0, col_reg < fw_reg,
        "column counter outside the frame width")
    `GB7_ASSERT_NOW(a_no_same_column, clk, rst_n,
        v1_reg, j1_reg != col_reg,
        "line store write and next read hit the same column")
    `GB7_ASSERT_NEXT(a_clear_after_last, clk, rst_n,
        acc && last0, taken_reg == '0 && given_reg == '0 && row_reg == '0,
        "frame counters not cleared after the final item")

endmodule

`default_nettype wire
